@@ sv/rtd_temperature_median_filter_core_assert.svh @@
// Assertion macros used by the checker file.
`ifndef RTD_TEMPERATURE_MEDIAN_FILTER_CORE_ASSERT_SVH
`define RTD_TEMPERATURE_MEDIAN_FILTER_CORE_ASSERT_SVH
// Immediate implication: when the antecedent holds, the consequent holds in the same cycle.
`define RTD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtd check failed");
// Next-cycle implication.
`define RTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtd check failed");
`endif

@@ sv/rtd_pkg.sv @@
`timescale 1ns / 1ps
package rtd_pkg;
    localparam int WINDOW_SIZE = 5;
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int DRAIN_W = $clog2(WINDOW_SIZE + 2);
    localparam int MED_IDX = WINDOW_SIZE / 2;
    localparam logic [15:0] COUNT_LIMIT = 16'd52800;
    localparam logic [31:0] R_OFFSET_Q = 32'd6553600;
    localparam logic [31:0] VALID_HIGH = 32'd100000;
    localparam logic [23:0] T_SCALE = 24'd10000000;
    localparam logic [27:0] T_DIV = 28'd252379136;
    // mag * 10^7 / (3851 * 2^16) equals mag * 78125 / (3851 * 2^9). It is taken as
    // (mag * T_RECIP) >> 53, which is exact for every 32-bit magnitude.
    localparam logic [48:0] T_RECIP = 49'((64'd78125 * (64'd1 << 44) + 64'd3850) / 64'd3851);
    localparam logic [31:0] SAT_ALL = 32'hFFFF_FFFF;
    localparam logic [1:0] ADDR_OFFSET = 2'd0;

    // Handshake between the converter and the sorting cells.
    typedef struct packed {
        logic        valid;
        logic [31:0] sample;
    } conv_req_t;
endpackage

@@ sv/rtd_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module rtd_divider
    import rtd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] quot_reg, quot_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quot_reg[63]} - {1'b0, dvs_reg};
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Shift one dividend bit into the remainder and try a subtract.
            if (!trial[32])
            begin
                rem_next  = trial;
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[31:0], quot_reg[63]};
                quot_next = {quot_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;
endmodule

@@ sv/rtd_converter.sv @@
`timescale 1ns / 1ps
// Count to resistance through a restoring divider, then to millidegrees by a reciprocal
// multiply split into a lower and an upper partial product.
module rtd_converter
    import rtd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [15:0]      raw_count,
    input  logic signed [17:0] offset,
    output conv_req_t        result
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RDIV = 6'b000010,
        S_MUL  = 6'b000100,
        S_PLO  = 6'b001000,
        S_PHI  = 6'b010000,
        S_OUT  = 6'b100000
    } conv_state_t;

    conv_state_t state_reg, state_next;
    logic [15:0] cnt_reg;
    logic        neg_reg;
    logic [31:0] mag_reg;
    logic [56:0] prod_reg;
    logic [27:0] tq_reg;
    logic [31:0] sample_reg, sample_next;
    logic        out_valid_reg, out_valid_next;
    logic        div_start;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [63:0] div_quot;
    logic [31:0] rq;
    logic [15:0] den;
    logic [40:0] num_r;
    logic [55:0] part_hi;
    logic [80:0] scaled;
    logic [32:0] t_ext;

    rtd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign den   = COUNT_LIMIT - cnt_reg;
    assign num_r = ({25'd0, cnt_reg} * 41'd330) << 16;
    assign div_dividend = {23'd0, num_r};
    assign div_divisor  = {16'd0, den};
    // Saturate the resistance to the Q16.16 range.
    assign rq    = (div_quot[63:32] != 32'd0) ? SAT_ALL : div_quot[31:0];
    // Upper partial product of the reciprocal multiply, summed with the registered lower one.
    assign part_hi = {24'd0, mag_reg} * {32'd0, T_RECIP[48:25]};
    assign scaled  = {part_hi, 25'd0} + {24'd0, prod_reg};
    assign t_ext = neg_reg ? (33'd0 - {5'd0, tq_reg}) : {5'd0, tq_reg};

    always_comb
    begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        out_valid_next = 1'b0;
        div_start      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (raw_count >= COUNT_LIMIT)
                    begin
                        sample_next = SAT_ALL;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RDIV;
                    end
                end
            end
            S_RDIV:
            begin
                div_start  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (div_done)
                begin
                    state_next = S_PLO;
                end
            end
            S_PLO:
            begin
                state_next = S_PHI;
            end
            S_PHI:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Saturated counts keep the all-ones sample; others get the offset modulo 2^32.
                if (cnt_reg < COUNT_LIMIT)
                begin
                    sample_next = t_ext[31:0] + {{14{offset[17]}}, offset};
                end
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: latched count, sign and magnitude, partial product, scaled magnitude and output sample.
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        if (state_reg == S_IDLE && start)
        begin
            cnt_reg <= raw_count;
        end
        if (state_reg == S_MUL && div_done)
        begin
            neg_reg <= rq < R_OFFSET_Q;
            mag_reg <= (rq < R_OFFSET_Q) ? (R_OFFSET_Q - rq) : (rq - R_OFFSET_Q);
        end
        if (state_reg == S_PLO)
        begin
            prod_reg <= {25'd0, mag_reg} * {32'd0, T_RECIP[24:0]};
        end
        if (state_reg == S_PHI)
        begin
            tq_reg <= scaled[80:53];
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.sample = sample_reg;
endmodule

@@ sv/rtd_sort_cell.sv @@
`timescale 1ns / 1ps
// One cell of an insertion-sort chain. It keeps the smaller value and passes the larger on.
module rtd_sort_cell
    import rtd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  logic        in_valid,
    input  logic [31:0] in_data,
    output logic        out_valid,
    output logic [31:0] out_data,
    output logic [31:0] held
);
    logic        full_reg;
    logic [31:0] data_reg;
    logic        ov_reg;
    logic [31:0] od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else if (clear)
        begin
            full_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            ov_reg <= in_valid && full_reg;
            if (in_valid)
            begin
                full_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            if (!full_reg)
            begin
                data_reg <= in_data;
            end
            else if (in_data < data_reg)
            begin
                data_reg <= in_data;
                od_reg   <= data_reg;
            end
            else
            begin
                od_reg <= in_data;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign held      = data_reg;
endmodule

@@ sv/rtd_temperature_median_filter_core.sv @@
`timescale 1ns / 1ps
// Median-of-five RTD filter. Each request carries one converter count, which becomes a
// resistance through a 64-step restoring divider and then a millidegree temperature through
// a reciprocal multiply in a lower and an upper partial product before the offset is added.
// A new request is accepted only after the previous sample has reached the sorting chain,
// the chain has settled and the input ready has been raised again. Counts at or above the
// divider limit skip the arithmetic. Every fifth request yields a result holding the last
// in-range median and an error flag; other requests yield none, and the input is held off
// while a result waits.
module rtd_temperature_median_filter_core
    import rtd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] raw_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [16:0] held_temperature,
    output logic        sensor_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic signed [17:0] offset_reg;
    logic               busy_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [DRAIN_W-1:0] drain_reg;
    logic               out_valid_reg;
    logic [16:0]        temp_reg;
    logic               err_reg;
    conv_req_t          conv;
    logic               accept;
    logic               clear_chain;
    logic               cv   [WINDOW_SIZE+1];
    logic [31:0]        cd   [WINDOW_SIZE+1];
    logic [31:0]        held [WINDOW_SIZE];
    logic [31:0]        med;

    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == 1'b0) ? {{14{offset_reg[17]}}, offset_reg} : 32'd0;

    // Configuration register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2:2] == ADDR_OFFSET[0])
        begin
            offset_reg <= pwdata[17:0];
        end
    end

    assign accept   = in_valid && in_ready;
    assign in_ready = !busy_reg && !out_valid_reg;

    rtd_converter u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .raw_count (raw_count),
        .offset    (offset_reg),
        .result    (conv)
    );

    // Sorting chain: samples ripple through until each cell holds its rank.
    assign cv[0] = conv.valid;
    assign cd[0] = conv.sample;
    assign clear_chain = out_valid_reg && out_ready;
    for (genvar g = 0; g < WINDOW_SIZE; g++)
    begin : g_cell
        rtd_sort_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (clear_chain),
            .in_valid  (cv[g]),
            .in_data   (cd[g]),
            .out_valid (cv[g+1]),
            .out_data  (cd[g+1]),
            .held      (held[g])
        );
    end
    assign med = held[MED_IDX];

    // Sequencing: wait for conversion, then let the chain settle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            fill_reg      <= '0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
            temp_reg      <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            if (clear_chain)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (conv.valid)
            begin
                drain_reg <= DRAIN_W'(WINDOW_SIZE + 1);
            end
            else if (drain_reg != '0)
            begin
                drain_reg <= drain_reg - DRAIN_W'(1);
                if (drain_reg == DRAIN_W'(1))
                begin
                    busy_reg <= 1'b0;
                    if (fill_reg == CNT_W'(WINDOW_SIZE - 1))
                    begin
                        fill_reg      <= '0;
                        out_valid_reg <= 1'b1;
                        if (med > 32'd0 && med < VALID_HIGH)
                        begin
                            temp_reg <= med[16:0];
                            err_reg  <= 1'b0;
                        end
                        else
                        begin
                            err_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        fill_reg <= fill_reg + CNT_W'(1);
                    end
                end
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign held_temperature = temp_reg;
    assign sensor_error     = err_reg;
endmodule

@@ sv/rtd_checker.sv @@
`timescale 1ns / 1ps
`include "rtd_temperature_median_filter_core_assert.svh"
// Port-level checks on the filter.
module rtd_checker
    import rtd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] held_temperature,
    input logic        sensor_error,
    input logic        pready
);
    `RTD_ASSERT_IMPL(a_temp_range, clk, rst_n, out_valid, held_temperature < 17'd100000)
    `RTD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(held_temperature))
    `RTD_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
    `RTD_ASSERT_IMPL(a_pready, clk, rst_n, 1'b1, pready)
    `RTD_ASSERT_NEXT(a_err_hold, clk, rst_n, out_valid && !out_ready, $stable(sensor_error))
endmodule

bind rtd_temperature_median_filter_core rtd_checker u_rtd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .held_temperature (held_temperature),
    .sensor_error     (sensor_error),
    .pready           (pready)
);
